>>> src/vdh_pkg.sv
package vdh_pkg;

	localparam int MAX_VERTICES_DEF = 4096;
	localparam int MAX_BUCKETS_DEF  = 512;
	localparam int WORD_W           = 32;
	localparam int VID_W            = 12;
	localparam int CFG_W            = 10;
	localparam int DIV_STEPS        = WORD_W;
	localparam int QUEUE_DEPTH      = 2;

	typedef struct packed {
		logic [WORD_W-1:0] word_x;
		logic [WORD_W-1:0] word_y;
		logic [WORD_W-1:0] word_z;
	} vdh_in_t;

	typedef struct packed {
		logic [VID_W-1:0] vertex_id;
		logic             is_new;
		logic             overflow;
	} vdh_out_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_CLEAR,
		B_LRD,
		B_LCMP,
		B_HRD,
		B_HNODE,
		B_HCMP,
		B_INS,
		B_INS2
	} back_state_t;

endpackage

>>> src/vdh_front.sv
module vdh_front #(
	parameter int BW = 10,
	parameter int SW = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  vdh_pkg::vdh_in_t  vertex,
	input  logic [BW-1:0]     bucket_count,
	input  logic              clearing,
	input  logic              q_full,
	output logic              busy,
	output logic              push,
	output vdh_pkg::vdh_in_t  push_item,
	output logic [SW-1:0]     push_slot
);
	import vdh_pkg::*;

	localparam int CW = $clog2(DIV_STEPS);

	front_state_t state_q, state_d;
	vdh_in_t      item_q;
	logic [WORD_W-1:0] num_q;
	logic [BW-1:0]     rem_q;
	logic [CW-1:0]     cnt_q;
	logic [BW:0]       trial;
	logic [BW:0]       diff;
	logic              accept;

	assign busy   = (state_q != F_IDLE) || clearing;
	assign accept = start && !busy;
	assign push   = (state_q == F_PUSH) && !q_full;
	assign push_item = item_q;
	assign push_slot = SW'(rem_q);

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, num_q[WORD_W-1]};
	assign diff  = trial - {1'b0, bucket_count};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = (bucket_count != '0) ? F_DIV : F_PUSH;
				end
			end
			F_DIV: begin
				if (cnt_q == '0) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= vertex;
			num_q  <= vertex.word_x + vertex.word_y + vertex.word_z;
			rem_q  <= '0;
			cnt_q  <= CW'(DIV_STEPS - 1);
		end else if (state_q == F_DIV) begin
			num_q <= {num_q[WORD_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
			if (trial >= {1'b0, bucket_count}) begin
				rem_q <= diff[BW-1:0];
			end else begin
				rem_q <= trial[BW-1:0];
			end
		end
	end

endmodule

>>> src/vdh_queue.sv
module vdh_queue #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output logic [DW-1:0] pop_data
);
	import vdh_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [DW-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;

	assign full      = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> src/vdh_back.sv
module vdh_back #(
	parameter int MAX_VERTICES = 4096,
	parameter int MAX_BUCKETS  = 512,
	parameter int BW = 10,
	parameter int SW = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [vdh_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                    q_valid,
	input  vdh_pkg::vdh_in_t        q_item,
	input  logic [SW-1:0]           q_slot,
	output logic                    q_pop,
	output logic [BW-1:0]           bucket_count,
	output logic                    clearing,
	output logic                    strobe,
	output vdh_pkg::vdh_out_t       result
);
	import vdh_pkg::*;

	localparam int ND  = MAX_BUCKETS + MAX_VERTICES;
	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int NIW = $clog2(ND);
	localparam int NTW = $clog2(ND + 1);

	logic [2*WORD_W-1:0] vxy_mem  [MAX_VERTICES];
	logic [WORD_W-1:0]   vz_mem   [MAX_VERTICES];
	logic [NIW-1:0]      nnext_mem[ND];
	logic [VW-1:0]       nvidx_mem[ND];

	back_state_t state_q, state_d;
	logic [BW-1:0]  bc_q;
	logic [VW:0]    vtotal_q;
	logic [NTW-1:0] ntotal_q;
	logic [BW-1:0]  clr_q;
	vdh_in_t        item_q;
	logic [NIW-1:0] cur_q;
	logic [NIW-1:0] next_q;
	logic [VW-1:0]  vi_q;
	logic [VW:0]    idx_q;

	logic [2*WORD_W-1:0] vxy_rd_q;
	logic [WORD_W-1:0]   vz_rd_q;
	logic [NIW-1:0]      nnext_rd_q;
	logic [VW-1:0]       nvidx_rd_q;

	logic [VW-1:0]  vrd_addr;
	logic           nw_en;
	logic [NIW-1:0] nw_addr;
	logic [NIW-1:0] nw_next;
	logic [VW-1:0]  nw_vidx;
	logic           vw_en;
	logic           hit;
	logic           full;
	logic [BW-1:0]  cfg_sat;
	logic           emit;
	vdh_out_t       res_d;

	assign bucket_count = bc_q;
	assign clearing     = (state_q == B_CLEAR);
	assign q_pop        = (state_q == B_IDLE) && q_valid && !cfg_we;

	assign hit  = (vxy_rd_q == {item_q.word_y, item_q.word_x}) && (vz_rd_q == item_q.word_z);
	assign full = (vtotal_q >= (VW+1)'(MAX_VERTICES)) || (ntotal_q >= NTW'(ND));
	assign cfg_sat = (32'(cfg_wdata) > 32'(MAX_BUCKETS)) ? BW'(MAX_BUCKETS) : BW'(cfg_wdata);

	always_comb begin
		state_d  = state_q;
		vrd_addr = idx_q[VW-1:0];
		nw_en    = 1'b0;
		nw_addr  = cur_q;
		nw_next  = '0;
		nw_vidx  = '0;
		vw_en    = 1'b0;
		emit     = 1'b0;
		res_d    = '0;
		unique case (state_q)
			B_IDLE: begin
				if (cfg_we) begin
					state_d = (cfg_sat != '0) ? B_CLEAR : B_IDLE;
				end else if (q_valid) begin
					state_d = (bc_q != '0) ? B_HRD : B_LRD;
				end
			end
			B_CLEAR: begin
				nw_en   = 1'b1;
				nw_addr = NIW'(clr_q);
				if (clr_q == bc_q - 1'b1) begin
					state_d = B_IDLE;
				end
			end
			B_LRD: begin
				state_d = (idx_q >= vtotal_q) ? B_INS : B_LCMP;
			end
			B_LCMP: begin
				if (hit) begin
					emit = 1'b1;
					res_d.vertex_id = VID_W'(idx_q);
					state_d = B_IDLE;
				end else begin
					state_d = B_LRD;
				end
			end
			B_HRD: begin
				state_d = B_HNODE;
			end
			B_HNODE: begin
				vrd_addr = nvidx_rd_q;
				state_d  = (nnext_rd_q == '0) ? B_INS : B_HCMP;
			end
			B_HCMP: begin
				if (hit) begin
					emit = 1'b1;
					res_d.vertex_id = VID_W'(vi_q);
					state_d = B_IDLE;
				end else if (32'(next_q) >= 32'(ND)) begin
					state_d = B_INS;
				end else begin
					state_d = B_HRD;
				end
			end
			B_INS: begin
				if (full) begin
					emit = 1'b1;
					res_d.overflow = 1'b1;
					state_d = B_IDLE;
				end else begin
					vw_en = 1'b1;
					if (bc_q != '0) begin
						nw_en   = 1'b1;
						nw_next = ntotal_q[NIW-1:0];
						nw_vidx = vtotal_q[VW-1:0];
						state_d = B_INS2;
					end else begin
						emit = 1'b1;
						res_d.vertex_id = VID_W'(vtotal_q);
						res_d.is_new = 1'b1;
						state_d = B_IDLE;
					end
				end
			end
			B_INS2: begin
				// fresh empty end node for the extended chain
				nw_en   = 1'b1;
				nw_addr = ntotal_q[NIW-1:0];
				emit    = 1'b1;
				res_d.vertex_id = VID_W'(vtotal_q);
				res_d.is_new = 1'b1;
				state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			bc_q     <= '0;
			vtotal_q <= '0;
			ntotal_q <= '0;
			strobe   <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= emit;
			if (state_q == B_IDLE && cfg_we) begin
				bc_q     <= cfg_sat;
				vtotal_q <= '0;
				ntotal_q <= NTW'(cfg_sat);
			end
			if (state_q == B_INS && !full && bc_q == '0) begin
				vtotal_q <= vtotal_q + 1'b1;
			end
			if (state_q == B_INS2) begin
				vtotal_q <= vtotal_q + 1'b1;
				ntotal_q <= ntotal_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result <= res_d;
		end
		if (state_q == B_IDLE) begin
			clr_q <= '0;
			idx_q <= '0;
			if (q_pop) begin
				item_q <= q_item;
				cur_q  <= NIW'(q_slot);
			end
		end
		if (state_q == B_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
		if (state_q == B_LCMP) begin
			idx_q <= idx_q + 1'b1;
		end
		if (state_q == B_HNODE) begin
			next_q <= nnext_rd_q;
			vi_q   <= nvidx_rd_q;
		end
		if (state_q == B_HCMP && !hit && 32'(next_q) < 32'(ND)) begin
			cur_q <= next_q;
		end
	end

	// vertex store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (vw_en) begin
			vxy_mem[vtotal_q[VW-1:0]] <= {item_q.word_y, item_q.word_x};
			vz_mem[vtotal_q[VW-1:0]]  <= item_q.word_z;
		end
		vxy_rd_q <= vxy_mem[vrd_addr];
		vz_rd_q  <= vz_mem[vrd_addr];
	end

	// chain node store
	always_ff @(posedge clk) begin
		if (nw_en) begin
			nnext_mem[nw_addr] <= nw_next;
			nvidx_mem[nw_addr] <= nw_vidx;
		end
		nnext_rd_q <= nnext_mem[cur_q];
		nvidx_rd_q <= nvidx_mem[cur_q];
	end

endmodule

>>> src/vertex_dedup_hash_table.sv
// Vertex dedup table: each start transaction carries one vertex (three raw
// 32-bit words) and yields exactly one result transaction, a one-cycle strobe
// with the vertex index, is_new and overflow. The receiver cannot stall; every
// strobe must be captured. A front stage takes the vertex and, in hash mode,
// reduces x+y+z modulo bucket_count with a bit-serial remainder unit; a
// two-entry queue feeds a back stage that owns the stores. In linear mode
// (bucket_count 0) the back stage reads and then compares each stored vertex;
// in hash mode it reads, decodes and compares each occupied chain node.
// Reaching the end of the search takes one more read in linear mode and a read
// and decode of the empty end node in hash mode; appending writes the vertex
// (linear) or fills the end node and adds a fresh one (hash), and the strobe is
// registered from the final state. busy is high while the front holds a vertex
// and during the clearing pass that follows a nonzero bucket_count write, which
// clears one bucket head per cycle. Results come out in the order the vertices went in.
module vertex_dedup_hash_table #(
	parameter int MAX_VERTICES = vdh_pkg::MAX_VERTICES_DEF,
	parameter int MAX_BUCKETS  = vdh_pkg::MAX_BUCKETS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [vdh_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      start,
	input  vdh_pkg::vdh_in_t          vertex,
	output logic                      busy,
	output logic                      strobe,
	output vdh_pkg::vdh_out_t         result
);
	import vdh_pkg::*;

	localparam int BW = $clog2(MAX_BUCKETS + 1);
	localparam int SW = $clog2(MAX_BUCKETS);
	localparam int QW = $bits(vdh_in_t) + SW;

	logic          push, pop, q_full, q_valid, clearing;
	logic [BW-1:0] bucket_count;
	vdh_in_t       push_item;
	logic [SW-1:0] push_slot;
	logic [QW-1:0] q_data;

	// front: accept and bucket hash
	vdh_front #(.BW(BW), .SW(SW)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .vertex(vertex),
		.bucket_count(bucket_count), .clearing(clearing), .q_full(q_full),
		.busy(busy), .push(push), .push_item(push_item), .push_slot(push_slot)
	);

	vdh_queue #(.DW(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data({push_slot, push_item}),
		.pop(pop), .full(q_full), .not_empty(q_valid), .pop_data(q_data)
	);

	// back: search, insert, clear
	vdh_back #(
		.MAX_VERTICES(MAX_VERTICES), .MAX_BUCKETS(MAX_BUCKETS), .BW(BW), .SW(SW)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.q_valid(q_valid), .q_item(q_data[$bits(vdh_in_t)-1:0]),
		.q_slot(q_data[QW-1:$bits(vdh_in_t)]), .q_pop(pop),
		.bucket_count(bucket_count), .clearing(clearing),
		.strobe(strobe), .result(result)
	);

endmodule

>>> verif/vdh_checker.sv
`timescale 1ns / 100ps

// Watches the command, config and result channels of the dedup table,
// keeps its own index of stored vertices and checks every result strobe.
module vdh_checker
	import vdh_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  start,
	input  logic                  busy,
	input  vdh_in_t               vertex,
	input  logic                  strobe,
	input  vdh_out_t              result,
	output int                    errors,
	output int                    pending
);

	localparam int STORE_DEPTH = MAX_VERTICES_DEF;

	// vertex words -> stored index; indexes are unique, so the first match in
	// a linear scan and the hit in a bucket chain give the same index
	int          stored_index [bit [3*WORD_W-1:0]];
	int          stored_count;
	vdh_out_t    expected_ids [$];

	function automatic vdh_out_t find_or_append(vdh_in_t v);
		vdh_out_t r;
		bit [3*WORD_W-1:0] key;
		key = {v.word_x, v.word_y, v.word_z};
		r = '0;
		if (stored_index.exists(key)) begin
			r.vertex_id = VID_W'(stored_index[key]);
		end else if (stored_count >= STORE_DEPTH) begin
			r.overflow = 1'b1;
		end else begin
			r.vertex_id = VID_W'(stored_count);
			r.is_new = 1'b1;
			stored_index[key] = stored_count;
			stored_count++;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vdh_out_t exp_r;
		if (!arst_n) begin
			stored_index.delete();
			stored_count = 0;
			expected_ids.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				// any write empties the table
				stored_index.delete();
				stored_count = 0;
			end
			if (start && !busy)
				expected_ids.push_back(find_or_append(vertex));
			if (strobe) begin
				if (expected_ids.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected result id=%0d new=%0b ovf=%0b",
							$time, result.vertex_id, result.is_new, result.overflow);
					errors <= errors + 1;
				end else begin
					exp_r = expected_ids.pop_front();
					if (result !== exp_r) begin
						if (errors < 10)
							$display("%0t: mismatch exp id=%0d new=%0b ovf=%0b got id=%0d new=%0b ovf=%0b",
								$time, exp_r.vertex_id, exp_r.is_new, exp_r.overflow,
								result.vertex_id, result.is_new, result.overflow);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_ids.size();
		end
	end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the vertex dedup table. Checking lives in
// vdh_checker, which sits beside the DUT on the same wires.
module tb_top;
	import vdh_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             start = 1'b0;
	vdh_in_t          vertex = '0;
	logic             busy;
	logic             strobe;
	vdh_out_t         result;
	int               errors;
	int               pending;

	// vertices sent so far, reused to provoke hits
	vdh_in_t          sent_pool [$];
	bit               allow_idle = 1'b1;

	always #1 clk = ~clk;

	vertex_dedup_hash_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.start    (start),
		.vertex   (vertex),
		.busy     (busy),
		.strobe   (strobe),
		.result   (result)
	);

	vdh_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.start    (start),
		.busy     (busy),
		.vertex   (vertex),
		.strobe   (strobe),
		.result   (result),
		.errors   (errors),
		.pending  (pending)
	);

	// Called right after a rising edge. Optionally idles a burst, then holds
	// start until the transaction is taken. busy only moves on rising edges,
	// so checking it on the falling edge tells what the next edge will see.
	task automatic send_vertex(vdh_in_t v);
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		vertex <= v;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		sent_pool.push_back(v);
		if (sent_pool.size() > 64)
			void'(sent_pool.pop_front());
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// mostly fresh vertices, a good share of repeats for hits
	function automatic vdh_in_t rand_vertex();
		vdh_in_t v;
		if (sent_pool.size() > 0 && $urandom_range(0, 9) < 4)
			return sent_pool[$urandom_range(0, sent_pool.size() - 1)];
		v.word_x = rand_word();
		v.word_y = rand_word();
		v.word_z = rand_word();
		return v;
	endfunction

	// Drain, let the back stage settle, then write the register. The clear
	// pass that follows a nonzero write raises busy, which send_vertex waits out.
	task automatic set_buckets(logic [CFG_W-1:0] n);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	task automatic run_random(int n);
		repeat (n) send_vertex(rand_vertex());
	endtask

	initial begin
		vdh_in_t v;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, linear search after reset: extremes, repeats, bit patterns
		send_vertex('0);
		send_vertex('1);
		send_vertex('0);
		send_vertex({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
		send_vertex({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
		send_vertex('1);
		send_vertex({32'h0000_0001, 32'h0, 32'h0});
		send_vertex({32'h0, 32'h0000_0001, 32'h0});
		send_vertex({32'h0, 32'h0, 32'h0000_0001});
		send_vertex({32'h8000_0000, 32'h8000_0000, 32'h0});
		send_vertex({32'h0, 32'h0, 32'h0000_0001});
		run_random(200);

		// one bucket: every vertex on a single chain
		set_buckets(10'd1);
		send_vertex('0);
		send_vertex('1);
		send_vertex('0);
		// x+y+z wraps to zero
		send_vertex({32'hFFFF_FFFF, 32'h0000_0001, 32'h0});
		run_random(150);

		// above the maximum: saturates to the largest table
		set_buckets(10'h3FF);
		for (int i = 0; i < 300; i++) begin
			v.word_x = $urandom;
			v.word_y = $urandom;
			v.word_z = i;
			send_vertex(v);
			if (i % 16 == 0)
				send_vertex(sent_pool[$urandom_range(0, sent_pool.size() - 1)]);
		end

		set_buckets(10'd7);
		run_random(400);

		set_buckets(10'd0);
		run_random(300);

		// maximum buckets, last stretch with no idling
		set_buckets(10'd512);
		run_random(300);
		allow_idle = 1'b0;
		run_random(300);

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
